FILE: rtl/core/rlb_pkg.sv
// Shared types and codes for the replication log buffer.
`timescale 1ns / 1ps

package rlb_pkg;

    localparam int SECTOR_W = 48;
    localparam int PAGE_W   = 16;
    localparam int CAP_W    = 5;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD     = 3'd0,
        ACT_LOOKUP  = 3'd1,
        ACT_RESERVE = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_ADD_RES = 3'd4,
        ACT_RETIRE  = 3'd5
    } action_t;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STAT_W-1:0] ST_RES_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_ADD_RES_FAIL = 2'd3;

    localparam logic KIND_NOTICE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // One log entry as held in the entry memory.
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [SECTOR_W-1:0] log_sector;
        logic [PAGE_W-1:0]   page;
    } entry_t;

    // One incoming request.
    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [SECTOR_W-1:0] key_sector;
        logic [SECTOR_W-1:0] log_sector;
        logic [PAGE_W-1:0]   page_handle;
    } req_t;

    // One result item.
    typedef struct packed {
        logic                kind;
        logic [STAT_W-1:0]   status;
        logic                found;
        logic [SECTOR_W-1:0] found_log_sector;
        logic [PAGE_W-1:0]   result_page;
        logic                data_full;
        logic                inuse_full;
        logic                wake_waiters;
        logic                last;
    } result_t;

endpackage

FILE: rtl/core/rlb_mem.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module rlb_mem #(
    parameter int DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  rlb_pkg::entry_t           wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output rlb_pkg::entry_t           rd_data
);

    rlb_pkg::entry_t mem [DEPTH];
    rlb_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/rlb_ctrl.sv
// Request sequencer: ring pointers, counters, free walk and lookup walk.
`timescale 1ns / 1ps

module rlb_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rlb_pkg::CAP_W-1:0]       capacity,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  rlb_pkg::req_t                   req,
    input  logic                            out_free,
    output logic                            out_load,
    output rlb_pkg::result_t                out_data,
    output logic                            mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]        mem_wr_addr,
    output rlb_pkg::entry_t                 mem_wr_data,
    output logic                            mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]        mem_rd_addr,
    input  rlb_pkg::entry_t                 mem_rd_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int EW = $clog2(DEPTH + 1);
    localparam int CW = $clog2(2 * DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_FREE_RD   = 6'b000010,
        S_FREE_EMIT = 6'b000100,
        S_ADD_CHK   = 6'b001000,
        S_LOOK_CHK  = 6'b010000,
        S_FINISH    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0] data_head_reg, data_head_next;
    logic [IW-1:0] inuse_head_reg, inuse_head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [EW-1:0] data_entries_reg, data_entries_next;
    logic [EW-1:0] inuse_entries_reg, inuse_entries_next;
    logic [CW-1:0] data_count_reg, data_count_next;
    logic [CW-1:0] inuse_count_reg, inuse_count_next;

    logic [rlb_pkg::ACT_W-1:0]    act_reg, act_next;
    logic [rlb_pkg::SECTOR_W-1:0] key_reg, key_next;
    logic [rlb_pkg::SECTOR_W-1:0] log_reg, log_next;
    logic [rlb_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic [rlb_pkg::STAT_W-1:0]   status_reg, status_next;
    logic                         found_reg, found_next;
    logic [rlb_pkg::SECTOR_W-1:0] fls_reg, fls_next;
    logic [rlb_pkg::PAGE_W-1:0]   fpage_reg, fpage_next;
    logic                         wake_reg, wake_next;
    logic [IW-1:0]                look_idx_reg, look_idx_next;
    logic [EW-1:0]                look_left_reg, look_left_next;

    logic [CW-1:0] lim;
    logic [IW-1:0] tail_prev;
    logic [IW-1:0] look_prev;

    function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + IW'(1);
    endfunction

    function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] i);
        return (i == '0) ? LAST_SLOT : i - IW'(1);
    endfunction

    assign lim       = (32'(capacity) < DEPTH) ? CW'(capacity) : CW'(DEPTH);
    assign tail_prev = slot_dec(tail_reg);
    assign look_prev = slot_dec(look_idx_reg);

    always_comb begin
        state_next         = state_reg;
        data_head_next     = data_head_reg;
        inuse_head_next    = inuse_head_reg;
        tail_next          = tail_reg;
        data_entries_next  = data_entries_reg;
        inuse_entries_next = inuse_entries_reg;
        data_count_next    = data_count_reg;
        inuse_count_next   = inuse_count_reg;
        act_next           = act_reg;
        key_next           = key_reg;
        log_next           = log_reg;
        page_next          = page_reg;
        status_next        = status_reg;
        found_next         = found_reg;
        fls_next           = fls_reg;
        fpage_next         = fpage_reg;
        wake_next          = wake_reg;
        look_idx_next      = look_idx_reg;
        look_left_next     = look_left_reg;

        req_ready   = 1'b0;
        out_load    = 1'b0;
        out_data    = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = tail_reg;
        mem_wr_data = '{sector: key_reg, log_sector: log_reg, page: page_reg};
        mem_rd_en   = 1'b0;
        mem_rd_addr = data_head_reg;

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    act_next    = req.action;
                    key_next    = req.key_sector;
                    log_next    = req.log_sector;
                    page_next   = req.page_handle;
                    status_next = rlb_pkg::ST_OK;
                    found_next  = 1'b0;
                    fls_next    = '0;
                    fpage_next  = '0;
                    wake_next   = 1'b0;
                    state_next  = S_FINISH;
                    case (req.action)
                        rlb_pkg::ACT_ADD: begin
                            state_next = (data_count_reg >= lim) ? S_FREE_RD : S_ADD_CHK;
                        end
                        rlb_pkg::ACT_LOOKUP: begin
                            // Newest entry sits just below the tail.
                            if (inuse_entries_reg != '0) begin
                                mem_rd_en      = 1'b1;
                                mem_rd_addr    = tail_prev;
                                look_idx_next  = tail_prev;
                                look_left_next = inuse_entries_reg - EW'(1);
                                state_next     = S_LOOK_CHK;
                            end
                        end
                        rlb_pkg::ACT_RESERVE: begin
                            if (inuse_count_reg >= lim) begin
                                status_next = rlb_pkg::ST_RES_FULL;
                            end else begin
                                inuse_count_next = inuse_count_reg + CW'(1);
                                data_count_next  = data_count_reg + CW'(1);
                            end
                        end
                        rlb_pkg::ACT_RELEASE: begin
                            if (inuse_count_reg > CW'(inuse_entries_reg)) begin
                                inuse_count_next = inuse_count_reg - CW'(1);
                                data_count_next  = data_count_reg - CW'(1);
                                wake_next = (lim != '0) && (inuse_count_reg == lim);
                            end
                        end
                        rlb_pkg::ACT_ADD_RES: begin
                            // Drop the reservation first; restore it on failure.
                            if (inuse_count_reg > CW'(inuse_entries_reg)) begin
                                inuse_count_next = inuse_count_reg - CW'(1);
                                data_count_next  = data_count_reg - CW'(1);
                                state_next = (data_count_reg > lim) ? S_FREE_RD : S_ADD_CHK;
                            end else begin
                                status_next = rlb_pkg::ST_ADD_RES_FAIL;
                            end
                        end
                        rlb_pkg::ACT_RETIRE: begin
                            if (inuse_entries_reg != '0) begin
                                inuse_head_next    = slot_inc(inuse_head_reg);
                                inuse_entries_next = inuse_entries_reg - EW'(1);
                                inuse_count_next   = inuse_count_reg - CW'(1);
                                wake_next = (lim != '0) && (inuse_count_reg == lim);
                            end
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_FREE_RD: begin
                if (data_entries_reg > inuse_entries_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = data_head_reg;
                    state_next  = S_FREE_EMIT;
                end else begin
                    state_next = S_ADD_CHK;
                end
            end

            S_FREE_EMIT: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_data.kind        = rlb_pkg::KIND_NOTICE;
                    out_data.result_page = mem_rd_data.page;
                    data_head_next       = slot_inc(data_head_reg);
                    data_entries_next    = data_entries_reg - EW'(1);
                    data_count_next      = data_count_reg - CW'(1);
                    state_next           = S_FREE_RD;
                end
            end

            S_ADD_CHK: begin
                if (data_count_reg >= lim) begin
                    if (act_reg == rlb_pkg::ACT_ADD) begin
                        status_next = rlb_pkg::ST_FULL;
                    end else begin
                        status_next      = rlb_pkg::ST_ADD_RES_FAIL;
                        inuse_count_next = inuse_count_reg + CW'(1);
                        data_count_next  = data_count_reg + CW'(1);
                    end
                end else begin
                    mem_wr_en = 1'b1;
                    if (inuse_entries_reg == '0) begin
                        inuse_head_next = tail_reg;
                    end
                    tail_next          = slot_inc(tail_reg);
                    data_entries_next  = data_entries_reg + EW'(1);
                    inuse_entries_next = inuse_entries_reg + EW'(1);
                    data_count_next    = data_count_reg + CW'(1);
                    inuse_count_next   = inuse_count_reg + CW'(1);
                end
                state_next = S_FINISH;
            end

            S_LOOK_CHK: begin
                // Compare the entry read last cycle, fetch the next older one.
                if (mem_rd_data.sector == key_reg) begin
                    found_next = 1'b1;
                    fls_next   = mem_rd_data.log_sector;
                    fpage_next = mem_rd_data.page;
                    state_next = S_FINISH;
                end else if (look_left_reg != '0) begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = look_prev;
                    look_idx_next  = look_prev;
                    look_left_next = look_left_reg - EW'(1);
                end else begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    out_load                  = 1'b1;
                    out_data.kind             = rlb_pkg::KIND_STATUS;
                    out_data.status           = status_reg;
                    out_data.found            = found_reg;
                    out_data.found_log_sector = fls_reg;
                    out_data.result_page      = fpage_reg;
                    out_data.data_full        = (data_count_reg == lim);
                    out_data.inuse_full       = (inuse_count_reg == lim);
                    out_data.wake_waiters     = wake_reg;
                    out_data.last             = 1'b1;
                    state_next                = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            data_head_reg     <= '0;
            inuse_head_reg    <= '0;
            tail_reg          <= '0;
            data_entries_reg  <= '0;
            inuse_entries_reg <= '0;
            data_count_reg    <= '0;
            inuse_count_reg   <= '0;
        end else begin
            state_reg         <= state_next;
            data_head_reg     <= data_head_next;
            inuse_head_reg    <= inuse_head_next;
            tail_reg          <= tail_next;
            data_entries_reg  <= data_entries_next;
            inuse_entries_reg <= inuse_entries_next;
            data_count_reg    <= data_count_next;
            inuse_count_reg   <= inuse_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        log_reg       <= log_next;
        page_reg      <= page_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        fls_reg       <= fls_next;
        fpage_reg     <= fpage_next;
        wake_reg      <= wake_next;
        look_idx_reg  <= look_idx_next;
        look_left_reg <= look_left_next;
    end

`ifndef SYNTHESIS
    a_inuse_within_data: assert property (@(posedge aclk) disable iff (!aresetn)
        inuse_entries_reg <= data_entries_reg)
        else $error("in-use entries exceed data entries");

    a_counts_cover_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (data_count_reg >= CW'(data_entries_reg)) &&
        (inuse_count_reg >= CW'(inuse_entries_reg)))
        else $error("count below number of stored entries");

    a_ring_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(data_entries_reg) <= DEPTH)
        else $error("data entries exceed ring depth");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded while output register busy");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");
`endif

endmodule

FILE: rtl/core/replication_log_buffer_top.sv
// Top level of the replication log buffer: config register, output register, core.
`timescale 1ns / 1ps

// Replication log buffer. A ring of DEPTH entries (disk sector, log sector,
// page handle) kept in a single-port-read, single-port-write entry memory.
// Requests arrive on s_* (valid/ready) and each one yields zero or more
// page-free notices (m_kind = 0) followed by exactly one final status
// (m_kind = 1, m_last = 1) on m_*. One request is worked on at a time;
// s_ready is high while the sequencer is idle, and an output register lets
// the next request in while the previous final status still waits for
// m_ready. When the buffer is full, an add or an add reserved first frees
// every acknowledged entry, oldest first; a lookup searches the in-use
// entries newest first and stops at the first match. The capacity register
// is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while no request is in flight, and the block itself does not enforce
// this. The limit in force is the smaller of capacity and DEPTH, and
// capacity 0 keeps the buffer full. Entry memory contents need no clearing
// after reset: only entries that were written are ever read back.

module replication_log_buffer_top #(
    parameter int DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [rlb_pkg::CAP_W-1:0]          cfg_wr_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rlb_pkg::ACT_W-1:0]          s_action,
    input  logic [rlb_pkg::SECTOR_W-1:0]       s_key_sector,
    input  logic [rlb_pkg::SECTOR_W-1:0]       s_log_sector,
    input  logic [rlb_pkg::PAGE_W-1:0]         s_page_handle,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_kind,
    output logic [rlb_pkg::STAT_W-1:0]         m_status,
    output logic                               m_found,
    output logic [rlb_pkg::SECTOR_W-1:0]       m_found_log_sector,
    output logic [rlb_pkg::PAGE_W-1:0]         m_result_page,
    output logic                               m_data_full,
    output logic                               m_inuse_full,
    output logic                               m_wake_waiters,
    output logic                               m_last
);

    localparam int IW = $clog2(DEPTH);

    logic [rlb_pkg::CAP_W-1:0] capacity_reg;

    rlb_pkg::req_t    req;
    rlb_pkg::result_t out_data;
    rlb_pkg::result_t out_reg;
    logic             m_valid_reg;
    logic             out_free;
    logic             out_load;

    logic             mem_wr_en;
    logic [IW-1:0]    mem_wr_addr;
    rlb_pkg::entry_t  mem_wr_data;
    logic             mem_rd_en;
    logic [IW-1:0]    mem_rd_addr;
    rlb_pkg::entry_t  mem_rd_data;

    // Capacity register: write on enable, no handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= rlb_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Bundle the request fields for the sequencer.
    assign req = '{action:      s_action,
                   key_sector:  s_key_sector,
                   log_sector:  s_log_sector,
                   page_handle: s_page_handle};

    // Output register: load when empty or being drained, drop valid on take.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_data;
        end
    end

    rlb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .capacity    (capacity_reg),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (req),
        .out_free    (out_free),
        .out_load    (out_load),
        .out_data    (out_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    rlb_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_valid            = m_valid_reg;
    assign m_kind             = out_reg.kind;
    assign m_status           = out_reg.status;
    assign m_found            = out_reg.found;
    assign m_found_log_sector = out_reg.found_log_sector;
    assign m_result_page      = out_reg.result_page;
    assign m_data_full        = out_reg.data_full;
    assign m_inuse_full       = out_reg.inuse_full;
    assign m_wake_waiters     = out_reg.wake_waiters;
    assign m_last             = out_reg.last;

endmodule

FILE: test/tb_replication_log_buffer_top.sv
// Self-checking testbench for the replication log buffer top level.
`timescale 1ns / 1ps

module tb_replication_log_buffer_top;

    localparam int RING_DEPTH      = 16;
    localparam int CYCLE_LIMIT     = 2000000;
    // Settle time covers the longest request, which walks the whole ring once.
    localparam int SETTLE_CYCLES   = RING_DEPTH + 8;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int PHASE_COUNT     = 6;
    localparam int KEY_POOL_SIZE   = 8;

    // Action codes the block has no meaning for; it must answer them with a plain ok.
    localparam logic [rlb_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [rlb_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    // Mirror of the ring, its counters and the capacity register. Each accepted
    // request is turned into the list of results it must produce; results coming
    // out of the block are matched in order against that list.
    class ring_tracker;
        logic [rlb_pkg::SECTOR_W-1:0] sector_mem [RING_DEPTH];
        logic [rlb_pkg::SECTOR_W-1:0] log_mem    [RING_DEPTH];
        logic [rlb_pkg::PAGE_W-1:0]   page_mem   [RING_DEPTH];
        int unsigned                  ring_head, unacked_head, ring_tail;
        int unsigned                  stored_n, unacked_n, data_used, inuse_used;
        logic [rlb_pkg::CAP_W-1:0]    cap_reg;
        rlb_pkg::result_t             due_results [$];
        int unsigned                  mismatches;

        function new();
            ring_head    = 0;
            unacked_head = 0;
            ring_tail    = 0;
            stored_n     = 0;
            unacked_n    = 0;
            data_used    = 0;
            inuse_used   = 0;
            cap_reg      = rlb_pkg::CAP_RESET;
            mismatches   = 0;
        endfunction

        function void set_capacity(logic [rlb_pkg::CAP_W-1:0] value);
            cap_reg = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int unsigned limit();
            return (cap_reg < RING_DEPTH) ? cap_reg : RING_DEPTH;
        endfunction

        function logic wake_due();
            return (limit() > 0) && (inuse_used == limit() - 1);
        endfunction

        // Drop every acknowledged entry, oldest first, one page-free notice each.
        function void free_acked();
            rlb_pkg::result_t notice;
            while (stored_n > unacked_n) begin
                notice             = '0;
                notice.kind        = rlb_pkg::KIND_NOTICE;
                notice.result_page = page_mem[ring_head];
                due_results.push_back(notice);
                ring_head = (ring_head + 1) % RING_DEPTH;
                stored_n--;
                data_used--;
            end
        endfunction

        function bit append_entry(rlb_pkg::req_t q);
            if (data_used >= limit())
                free_acked();
            if (data_used >= limit())
                return 1'b0;
            sector_mem[ring_tail] = q.key_sector;
            log_mem[ring_tail]    = q.log_sector;
            page_mem[ring_tail]   = q.page_handle;
            if (unacked_n == 0)
                unacked_head = ring_tail;
            ring_tail = (ring_tail + 1) % RING_DEPTH;
            stored_n++;
            unacked_n++;
            data_used++;
            inuse_used++;
            return 1'b1;
        endfunction

        function void note_request(rlb_pkg::req_t q);
            rlb_pkg::result_t fin;
            int unsigned      idx;
            fin = '0;
            case (q.action)
                rlb_pkg::ACT_ADD: begin
                    if (!append_entry(q))
                        fin.status = rlb_pkg::ST_FULL;
                end
                rlb_pkg::ACT_LOOKUP: begin
                    // Newest in-use entry first; stop at the first hit.
                    idx = ring_tail;
                    for (int unsigned i = 0; i < unacked_n && !fin.found; i++) begin
                        idx = (idx + RING_DEPTH - 1) % RING_DEPTH;
                        if (sector_mem[idx] == q.key_sector) begin
                            fin.found            = 1'b1;
                            fin.found_log_sector = log_mem[idx];
                            fin.result_page      = page_mem[idx];
                        end
                    end
                end
                rlb_pkg::ACT_RESERVE: begin
                    if (inuse_used >= limit()) begin
                        fin.status = rlb_pkg::ST_RES_FULL;
                    end else begin
                        inuse_used++;
                        data_used++;
                    end
                end
                rlb_pkg::ACT_RELEASE: begin
                    if (inuse_used > unacked_n) begin
                        inuse_used--;
                        data_used--;
                        fin.wake_waiters = wake_due();
                    end
                end
                rlb_pkg::ACT_ADD_RES: begin
                    if (inuse_used > unacked_n) begin
                        // Hand the reservation back, and take it again if the add fails.
                        inuse_used--;
                        data_used--;
                        if (!append_entry(q)) begin
                            inuse_used++;
                            data_used++;
                            fin.status = rlb_pkg::ST_ADD_RES_FAIL;
                        end
                    end else begin
                        fin.status = rlb_pkg::ST_ADD_RES_FAIL;
                    end
                end
                rlb_pkg::ACT_RETIRE: begin
                    if (unacked_n > 0) begin
                        unacked_head = (unacked_head + 1) % RING_DEPTH;
                        unacked_n--;
                        inuse_used--;
                        fin.wake_waiters = wake_due();
                    end
                end
                default: ;
            endcase
            fin.kind       = rlb_pkg::KIND_STATUS;
            fin.data_full  = (data_used == limit());
            fin.inuse_full = (inuse_used == limit());
            fin.last       = 1'b1;
            due_results.push_back(fin);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(rlb_pkg::result_t got);
            rlb_pkg::result_t want;
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: 0x%0h", got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("status", want.status, got.status);
            compare_field("found", want.found, got.found);
            compare_field("found_log_sector", want.found_log_sector, got.found_log_sector);
            compare_field("result_page", want.result_page, got.result_page);
            compare_field("data_full", want.data_full, got.data_full);
            compare_field("inuse_full", want.inuse_full, got.inuse_full);
            compare_field("wake_waiters", want.wake_waiters, got.wake_waiters);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [rlb_pkg::CAP_W-1:0]    cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [rlb_pkg::ACT_W-1:0]    s_action;
    logic [rlb_pkg::SECTOR_W-1:0] s_key_sector;
    logic [rlb_pkg::SECTOR_W-1:0] s_log_sector;
    logic [rlb_pkg::PAGE_W-1:0]   s_page_handle;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_kind;
    logic [rlb_pkg::STAT_W-1:0]   m_status;
    logic                         m_found;
    logic [rlb_pkg::SECTOR_W-1:0] m_found_log_sector;
    logic [rlb_pkg::PAGE_W-1:0]   m_result_page;
    logic                         m_data_full;
    logic                         m_inuse_full;
    logic                         m_wake_waiters;
    logic                         m_last;

    ring_tracker                  tracker = new();
    bit                           steady_flow = 1'b0;
    int unsigned                  cycle_count = 0;
    logic [rlb_pkg::SECTOR_W-1:0] key_pool [KEY_POOL_SIZE];

    replication_log_buffer_top #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_key_sector      (s_key_sector),
        .s_log_sector      (s_log_sector),
        .s_page_handle     (s_page_handle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_status          (m_status),
        .m_found           (m_found),
        .m_found_log_sector(m_found_log_sector),
        .m_result_page     (m_result_page),
        .m_data_full       (m_data_full),
        .m_inuse_full      (m_inuse_full),
        .m_wake_waiters    (m_wake_waiters),
        .m_last            (m_last)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    // Steady-flow phases drop all idling on both sides.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rlb_pkg::SECTOR_W-1:0] rand48();
        logic [63:0] word;
        word = {$urandom, $urandom};
        return word[rlb_pkg::SECTOR_W-1:0];
    endfunction

    // Result side: stall m_ready in random bursts, change it at the falling edge.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // Sample each accepted result at the rising edge and check it.
    initial begin
        rlb_pkg::result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.kind             = m_kind;
                got.status           = m_status;
                got.found            = m_found;
                got.found_log_sector = m_found_log_sector;
                got.result_page      = m_result_page;
                got.data_full        = m_data_full;
                got.inuse_full       = m_inuse_full;
                got.wake_waiters     = m_wake_waiters;
                got.last             = m_last;
                tracker.check_result(got);
            end
        end
    end

    // Present one request, hold it until accepted, then record what it must produce.
    // Valid is left high on return; the next call either replaces the payload at the
    // next falling edge or lowers valid for a gap.
    task automatic send_request(input logic [rlb_pkg::ACT_W-1:0] act,
                                input logic [rlb_pkg::SECTOR_W-1:0] key,
                                input logic [rlb_pkg::SECTOR_W-1:0] lsec,
                                input logic [rlb_pkg::PAGE_W-1:0] page);
        rlb_pkg::req_t req;
        int            gap;
        req.action      = act;
        req.key_sector  = key;
        req.log_sector  = lsec;
        req.page_handle = page;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_key_sector  <= key;
        s_log_sector  <= lsec;
        s_page_handle <= page;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(req);
    endtask

    // Lower valid, wait for every outstanding result, then let the block settle.
    task automatic drain_requests();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called with nothing in flight.
    task automatic write_capacity(input logic [rlb_pkg::CAP_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_capacity(value);
    endtask

    // One random request. Keys mostly come from a small pool so lookups hit and
    // the ring fills, frees and refills; ignored actions are not counted.
    task automatic issue_random_item(output bit counted);
        int                           roll;
        logic [rlb_pkg::ACT_W-1:0]    act;
        logic [rlb_pkg::SECTOR_W-1:0] key;
        roll = $urandom_range(0, 99);
        if (roll < 34)
            act = rlb_pkg::ACT_ADD;
        else if (roll < 52)
            act = rlb_pkg::ACT_LOOKUP;
        else if (roll < 62)
            act = rlb_pkg::ACT_RESERVE;
        else if (roll < 70)
            act = rlb_pkg::ACT_RELEASE;
        else if (roll < 80)
            act = rlb_pkg::ACT_ADD_RES;
        else if (roll < 97)
            act = rlb_pkg::ACT_RETIRE;
        else
            act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
        if ($urandom_range(0, 9) < 7)
            key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else
            key = rand48();
        send_request(act, key, rand48(), rlb_pkg::PAGE_W'($urandom_range(0, 65535)));
        counted = (act != ACT_SPARE_LO) && (act != ACT_SPARE_HI);
    endtask

    initial begin
        logic [rlb_pkg::CAP_W-1:0]    phase_caps [PHASE_COUNT];
        logic [rlb_pkg::SECTOR_W-1:0] key_a;
        int                           sent;
        bit                           counted;

        // Drive every input to a known value from time zero; hold reset.
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_action      = rlb_pkg::ACT_ADD;
        s_key_sector  = '0;
        s_log_sector  = '0;
        s_page_handle = '0;
        phase_caps    = '{5'd31, 5'd4, 5'd16, 5'd7, 5'd2, 5'd12};
        foreach (key_pool[k])
            key_pool[k] = rand48();
        key_a = rand48();

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-buffer corner cases at the reset capacity.
        send_request(rlb_pkg::ACT_RETIRE, '0, '0, '0);   // retire with nothing in use
        send_request(rlb_pkg::ACT_RELEASE, '0, '0, '0);  // release without reservation
        send_request(rlb_pkg::ACT_ADD_RES, '0, '0, '0);  // add reserved without reservation
        send_request(ACT_SPARE_LO, rand48(), rand48(), '1);
        send_request(ACT_SPARE_HI, '1, '1, '1);
        send_request(rlb_pkg::ACT_LOOKUP, '0, '0, '0);   // lookup on an empty ring
        send_request(rlb_pkg::ACT_ADD, '1, '0, '1);      // field extremes, both ways
        send_request(rlb_pkg::ACT_ADD, '0, '1, '0);
        send_request(rlb_pkg::ACT_LOOKUP, '1, '0, '0);
        send_request(rlb_pkg::ACT_LOOKUP, '0, '0, '0);
        drain_requests();

        // Shrink to two: both counts sit at the limit.
        write_capacity(5'd2);
        send_request(rlb_pkg::ACT_RESERVE, '0, '0, '0);  // refused, in-use full
        // Full, nothing acknowledged to free.
        send_request(rlb_pkg::ACT_ADD, rand48(), rand48(), 16'h1234);
        send_request(rlb_pkg::ACT_RETIRE, '0, '0, '0);   // drops to limit-1: wake
        // Frees one acknowledged entry.
        send_request(rlb_pkg::ACT_ADD, rand48(), rand48(), 16'h5678);
        send_request(rlb_pkg::ACT_RETIRE, '0, '0, '0);
        send_request(rlb_pkg::ACT_RETIRE, '0, '0, '0);
        send_request(rlb_pkg::ACT_RESERVE, '0, '0, '0);  // data count goes past the limit
        // Frees two, then adds.
        send_request(rlb_pkg::ACT_ADD_RES, key_a, rand48(), 16'hA5A5);
        send_request(rlb_pkg::ACT_RESERVE, '0, '0, '0);
        drain_requests();

        // Lower the limit under the held counts.
        write_capacity(5'd1);
        // No room, keep the reservation.
        send_request(rlb_pkg::ACT_ADD_RES, rand48(), rand48(), 16'h0F0F);
        send_request(rlb_pkg::ACT_RELEASE, '0, '0, '0);
        drain_requests();

        // Capacity zero: always full.
        write_capacity(5'd0);
        send_request(rlb_pkg::ACT_ADD, rand48(), rand48(), 16'hFFFF);
        send_request(rlb_pkg::ACT_RESERVE, '0, '0, '0);
        send_request(rlb_pkg::ACT_LOOKUP, key_a, '0, '0);
        send_request(rlb_pkg::ACT_RETIRE, '0, '0, '0);
        drain_requests();

        // Random phases, each at its own capacity; one phase with no idling at all.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(phase_caps[p]);
            steady_flow = (p == 2);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // Now and then hold off the sender until every result is back.
                if ($urandom_range(0, 39) == 0)
                    drain_requests();
                issue_random_item(counted);
                if (counted)
                    sent++;
            end
            drain_requests();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
